// File: design/ath_pkg.sv
// ----------------------------------------------------------------------------
// ath_pkg: shared types and constants for the antenna tuner handshake FSM
// Holds the phase encoding, status codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package ath_pkg;

	// Width of every configuration register
	localparam int unsigned CFG_W = 13;
	// APB address width: five registers at byte addresses 0..16
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	typedef enum logic [2:0] {
		PH_IDLE          = 3'd0,
		PH_TUNE_REQ      = 3'd1,
		PH_BYP_REQ       = 3'd2,
		PH_BYP_PULSE     = 3'd3,
		PH_KEY_LOW_WAIT  = 3'd4,
		PH_START_HOLD    = 3'd5,
		PH_KEY_HIGH_WAIT = 3'd6,
		PH_ERR_WINDOW    = 3'd7
	} phase_t;

	typedef enum logic [2:0] {
		REG_OVERALL_TIMEOUT = 3'd0,
		REG_BYPASS_PULSE    = 3'd1,
		REG_KEY_WAIT        = 3'd2,
		REG_START_HOLD      = 3'd3,
		REG_ERROR_WINDOW    = 3'd4
	} reg_idx_t;

	// Status byte codes
	localparam logic [7:0] ST_OK           = 8'h00;
	localparam logic [7:0] ST_CMD_TUNE     = 8'h01;
	localparam logic [7:0] ST_CMD_BYPASS   = 8'h02;
	localparam logic [7:0] ST_BYP_ACTIVE   = 8'h03;
	localparam logic [7:0] ST_KEY_WAIT     = 8'h04;
	localparam logic [7:0] ST_KEY_HIGH     = 8'h07;
	localparam logic [7:0] ST_SEND_RF      = 8'hEE;
	localparam logic [7:0] ST_FAIL_NOKEY   = 8'hFA;
	localparam logic [7:0] ST_FAIL_KEYWAIT = 8'hFB;
	localparam logic [7:0] ST_FAIL_PULSE   = 8'hFC;
	localparam logic [7:0] ST_FAIL_TIMEOUT = 8'hFD;

	// Register reset values
	localparam logic [CFG_W-1:0] RST_OVERALL_TIMEOUT = 13'd4000;
	localparam logic [CFG_W-1:0] RST_BYPASS_PULSE    = 13'd70;
	localparam logic [CFG_W-1:0] RST_KEY_WAIT        = 13'd600;
	localparam logic [CFG_W-1:0] RST_START_HOLD      = 13'd250;
	localparam logic [CFG_W-1:0] RST_ERROR_WINDOW    = 13'd60;

endpackage

// File: design/ath_if.sv
// ----------------------------------------------------------------------------
// ath_poll_if / ath_result_if: valid/ready channels of the tuner controller
// A transaction moves when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
interface ath_poll_if;
	logic       valid;
	logic       ready;
	logic       key_level;
	logic       host_write_valid;
	logic [7:0] host_write_value;
	logic [7:0] elapsed_ms;

	modport source (
		output valid, key_level, host_write_valid, host_write_value, elapsed_ms,
		input  ready
	);
	modport sink (
		input  valid, key_level, host_write_valid, host_write_value, elapsed_ms,
		output ready
	);
endinterface

interface ath_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] status_byte;
	logic       start_level;
	logic [2:0] phase_now;

	modport source (
		output valid, status_byte, start_level, phase_now,
		input  ready
	);
	modport sink (
		input  valid, status_byte, start_level, phase_now,
		output ready
	);
endinterface

// File: design/antenna_tuner_handshake_fsm.sv
// ----------------------------------------------------------------------------
// antenna_tuner_handshake_fsm: START/KEY handshake controller for a tuner
// Takes one poll transaction per cycle while the result side does not stall and returns one status transaction.
// ----------------------------------------------------------------------------
// Each poll transaction carries the sampled KEY level, an optional host write
// to the status register and the milliseconds elapsed since the last poll.
// The block answers every poll with exactly one result transaction holding
// the status byte, the START level and the phase after that poll. Throughput
// is one poll per clock cycle while the result side is not stalled; a result
// is offered once its poll has moved from the input register through the
// phase logic into the result register, and can be taken at the next rising
// edge. Both registers advance together, so a stalled result holds the input
// side only once the input register is also full. Thresholds
// are written through the APB port at byte address 4*i (overall timeout,
// bypass pulse, KEY wait, START hold, error window) and should only change
// while no poll is in flight.
module antenna_tuner_handshake_fsm #(
	parameter int unsigned TIMER_BITS = 13
) (
	input  logic                        clk,
	input  logic                        arst_n,
	ath_poll_if.sink                    poll,
	ath_result_if.source                result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ath_pkg::ADDR_W-1:0]  paddr,
	input  logic [ath_pkg::DATA_W-1:0]  pwdata,
	output logic [ath_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import ath_pkg::*;

	// Compare width covers both the timer and the thresholds
	localparam int unsigned CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
	localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

	// Configuration registers
	logic [CFG_W-1:0] overall_timeout_q;
	logic [CFG_W-1:0] bypass_pulse_q;
	logic [CFG_W-1:0] key_wait_q;
	logic [CFG_W-1:0] start_hold_q;
	logic [CFG_W-1:0] error_window_q;

	// Handshake state
	phase_t                phase_q;
	logic [TIMER_BITS-1:0] timer_q;
	logic [7:0]            status_q;
	logic                  start_q;

	// Input register
	logic       valid_s1;
	logic       key_s1;
	logic       wr_valid_s1;
	logic [7:0] wr_value_s1;
	logic [7:0] elapsed_s1;

	// Result register
	logic       res_valid_q;
	logic [7:0] res_status_q;
	logic       res_start_q;
	phase_t     res_phase_q;

	logic advance;

	// Phase logic signals
	logic [7:0]            status_wr;
	logic [TIMER_BITS:0]   timer_sum;
	logic [TIMER_BITS-1:0] timer_sat;
	logic [CMP_W-1:0]      timer_cmp;
	logic                  timeout;
	phase_t                phase_eff;
	logic [7:0]            status_eff;
	logic                  start_eff;
	phase_t                phase_d;
	logic [7:0]            status_d;
	logic                  start_d;
	logic [TIMER_BITS-1:0] timer_d;

	// ------------------------------------------------------------------
	// APB register file: writes complete in the access phase
	// ------------------------------------------------------------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overall_timeout_q <= RST_OVERALL_TIMEOUT;
			bypass_pulse_q    <= RST_BYPASS_PULSE;
			key_wait_q        <= RST_KEY_WAIT;
			start_hold_q      <= RST_START_HOLD;
			error_window_q    <= RST_ERROR_WINDOW;
		end else if (psel && penable && pwrite) begin
			case (reg_idx_t'(paddr[ADDR_W-1:2]))
				REG_OVERALL_TIMEOUT: overall_timeout_q <= pwdata[CFG_W-1:0];
				REG_BYPASS_PULSE:    bypass_pulse_q    <= pwdata[CFG_W-1:0];
				REG_KEY_WAIT:        key_wait_q        <= pwdata[CFG_W-1:0];
				REG_START_HOLD:      start_hold_q      <= pwdata[CFG_W-1:0];
				REG_ERROR_WINDOW:    error_window_q    <= pwdata[CFG_W-1:0];
				default: ;	// addresses beyond the list are ignored
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[ADDR_W-1:2]))
			REG_OVERALL_TIMEOUT: prdata = DATA_W'(overall_timeout_q);
			REG_BYPASS_PULSE:    prdata = DATA_W'(bypass_pulse_q);
			REG_KEY_WAIT:        prdata = DATA_W'(key_wait_q);
			REG_START_HOLD:      prdata = DATA_W'(start_hold_q);
			REG_ERROR_WINDOW:    prdata = DATA_W'(error_window_q);
			default:             prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Flow control: the input register drains into the result register
	// whenever the result register is empty or being taken this cycle.
	// ------------------------------------------------------------------
	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign poll.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	// Payload capture: no reset needed
	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			key_s1      <= poll.key_level;
			wr_valid_s1 <= poll.host_write_valid;
			wr_value_s1 <= poll.host_write_value;
			elapsed_s1  <= poll.elapsed_ms;
		end
	end

	// ------------------------------------------------------------------
	// Poll pre-processing: host write, timer advance, overall timeout
	// ------------------------------------------------------------------
	assign status_wr = wr_valid_s1 ? wr_value_s1 : status_q;
	assign timer_sum = {1'b0, timer_q} + (TIMER_BITS+1)'(elapsed_s1);
	// Saturate the timer at its maximum
	assign timer_sat = timer_sum[TIMER_BITS] ? TIMER_MAX : timer_sum[TIMER_BITS-1:0];
	assign timer_cmp = CMP_W'(timer_sat);
	assign timeout   = (phase_q != PH_IDLE) && (timer_cmp >= CMP_W'(overall_timeout_q));

	// A timeout drops to idle before the phase update runs
	assign phase_eff  = timeout ? PH_IDLE : phase_q;
	assign status_eff = timeout ? ST_FAIL_TIMEOUT : status_wr;
	assign start_eff  = timeout ? 1'b0 : start_q;

	// ------------------------------------------------------------------
	// Next phase
	// ------------------------------------------------------------------
	always_comb begin
		phase_d = phase_eff;
		case (phase_eff)
			PH_IDLE: begin
				if (status_eff == ST_CMD_TUNE) begin
					phase_d = PH_TUNE_REQ;
				end else if (status_eff == ST_CMD_BYPASS) begin
					phase_d = PH_BYP_REQ;
				end
			end
			PH_TUNE_REQ: begin
				phase_d = key_s1 ? PH_KEY_LOW_WAIT : PH_IDLE;
			end
			PH_BYP_REQ: begin
				phase_d = PH_BYP_PULSE;
			end
			PH_BYP_PULSE: begin
				if (timer_cmp >= CMP_W'(bypass_pulse_q)) begin
					phase_d = PH_IDLE;
				end
			end
			PH_KEY_LOW_WAIT: begin
				if (!key_s1) begin
					phase_d = PH_START_HOLD;
				end else if (timer_cmp >= CMP_W'(key_wait_q)) begin
					phase_d = PH_IDLE;
				end
			end
			PH_START_HOLD: begin
				if (timer_cmp >= CMP_W'(start_hold_q)) begin
					phase_d = PH_KEY_HIGH_WAIT;
				end
			end
			PH_KEY_HIGH_WAIT: begin
				if (key_s1) begin
					phase_d = PH_ERR_WINDOW;
				end
			end
			PH_ERR_WINDOW: begin
				if (!key_s1 || (timer_cmp >= CMP_W'(error_window_q))) begin
					phase_d = PH_IDLE;
				end
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Status, START and timer updates per phase
	// ------------------------------------------------------------------
	always_comb begin
		status_d = status_eff;
		start_d  = start_eff;
		timer_d  = timer_sat;
		case (phase_eff)
			PH_IDLE: begin
				// Restart the timer when a command leaves idle
				if (status_eff == ST_CMD_TUNE || status_eff == ST_CMD_BYPASS) begin
					timer_d = '0;
				end
			end
			PH_TUNE_REQ: begin
				if (!key_s1) begin
					status_d = ST_FAIL_NOKEY;
					start_d  = 1'b0;
				end else begin
					status_d = ST_KEY_WAIT;
					start_d  = 1'b1;
				end
			end
			PH_BYP_REQ: begin
				status_d = ST_BYP_ACTIVE;
				start_d  = 1'b1;
			end
			PH_BYP_PULSE: begin
				if (timer_cmp >= CMP_W'(bypass_pulse_q)) begin
					status_d = ST_OK;
					start_d  = 1'b0;
				end
			end
			PH_KEY_LOW_WAIT: begin
				if (!key_s1) begin
					status_d = ST_SEND_RF;
					timer_d  = '0;
				end else if (timer_cmp >= CMP_W'(key_wait_q)) begin
					status_d = ST_FAIL_KEYWAIT;
					start_d  = 1'b0;
				end
			end
			PH_START_HOLD: begin
				// Drop START; status stays as it was
				if (timer_cmp >= CMP_W'(start_hold_q)) begin
					start_d = 1'b0;
				end
			end
			PH_KEY_HIGH_WAIT: begin
				if (key_s1) begin
					status_d = ST_KEY_HIGH;
					timer_d  = '0;
				end
			end
			PH_ERR_WINDOW: begin
				if (!key_s1) begin
					status_d = ST_FAIL_PULSE;
					start_d  = 1'b0;
				end else if (timer_cmp >= CMP_W'(error_window_q)) begin
					status_d = ST_OK;
					start_d  = 1'b0;
				end
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// State and result registers advance together
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			timer_q     <= '0;
			status_q    <= ST_OK;
			start_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q     <= phase_d;
				timer_q     <= timer_d;
				status_q    <= status_d;
				start_q     <= start_d;
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_status_q <= status_d;
			res_start_q  <= start_d;
			res_phase_q  <= phase_d;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.status_byte = res_status_q;
	assign result.start_level = res_start_q;
	assign result.phase_now   = res_phase_q;

endmodule

// File: test/tb_antenna_tuner_handshake_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_antenna_tuner_handshake_fsm: self-checking bench for the tuner controller
// Drives poll transactions through the valid/ready channel and programs the
// thresholds over APB. Every result is checked against an in-bench model of
// the START/KEY phase machine: a short scripted sequence first, then random
// tune, bypass, broken and noise sessions under several threshold settings.
// ----------------------------------------------------------------------------
module tb_antenna_tuner_handshake_fsm;
	import ath_pkg::*;

	localparam int unsigned TIMER_BITS = 13;
	localparam int TIMER_MAX = (1 << TIMER_BITS) - 1;
	// cycles with no transaction on any port before the run is declared hung
	localparam int HANG_LIMIT = 1000;
	// length of the forced receiver hold-off that backs up the pipeline
	localparam int SQUEEZE_CYCLES = 80;

	typedef struct packed {
		logic       key_level;
		logic       host_write_valid;
		logic [7:0] host_write_value;
		logic [7:0] elapsed_ms;
	} poll_t;

	typedef struct packed {
		logic [7:0] status_byte;
		logic       start_level;
		phase_t     phase_now;
	} tuner_out_t;

	// one scripted poll; pinned rows carry a hand-written expectation
	typedef struct {
		poll_t      stim;
		bit         pinned;
		tuner_out_t want;
	} script_row_t;

	typedef struct {
		bit         pinned;
		tuner_out_t want;
	} pin_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	ath_poll_if   poll_bus();
	ath_result_if result_bus();

	antenna_tuner_handshake_fsm #(
		.TIMER_BITS(TIMER_BITS)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.poll   (poll_bus),
		.result (result_bus),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	// ------------------------------------------------------------------
	// Model of the controller: thresholds, phase, timer, status, START
	// ------------------------------------------------------------------
	logic [CFG_W-1:0] tuner_cfg [5] = '{RST_OVERALL_TIMEOUT, RST_BYPASS_PULSE,
		RST_KEY_WAIT, RST_START_HOLD, RST_ERROR_WINDOW};
	phase_t                model_phase  = PH_IDLE;
	logic [TIMER_BITS-1:0] model_timer  = '0;
	logic [7:0]            model_status = ST_OK;
	logic                  model_start  = 1'b0;

	tuner_out_t status_expect_q [$];
	pin_t       pinned_q [$];

	int mismatch_count = 0;
	int idle_cycles    = 0;
	int burst_left     = 0;
	bit long_stall_req = 1'b0;

	function automatic void drop_to_idle(input logic [7:0] code);
		model_start  = 1'b0;
		model_phase  = PH_IDLE;
		model_status = code;
	endfunction

	// Advance the model by one poll and return what the block should report.
	function automatic tuner_out_t advance_tuner_model(input poll_t p);
		int sum;
		tuner_out_t r;
		// host write lands first, then the timer moves and saturates
		if (p.host_write_valid)
			model_status = p.host_write_value;
		sum = int'(model_timer) + int'(p.elapsed_ms);
		model_timer = (sum > TIMER_MAX) ? TIMER_BITS'(TIMER_MAX) : TIMER_BITS'(sum);
		// overall timeout aborts any active phase before the phase logic runs
		if (model_phase != PH_IDLE && model_timer >= tuner_cfg[REG_OVERALL_TIMEOUT])
			drop_to_idle(ST_FAIL_TIMEOUT);
		case (model_phase)
			PH_IDLE: begin
				if (model_status == ST_CMD_TUNE) begin
					model_phase = PH_TUNE_REQ;
					model_timer = '0;
				end else if (model_status == ST_CMD_BYPASS) begin
					model_phase = PH_BYP_REQ;
					model_timer = '0;
				end
			end
			PH_TUNE_REQ: begin
				// no timer restart here: the KEY wait counts from leaving idle
				if (!p.key_level) begin
					drop_to_idle(ST_FAIL_NOKEY);
				end else begin
					model_start  = 1'b1;
					model_phase  = PH_KEY_LOW_WAIT;
					model_status = ST_KEY_WAIT;
				end
			end
			PH_BYP_REQ: begin
				model_start  = 1'b1;
				model_phase  = PH_BYP_PULSE;
				model_status = ST_BYP_ACTIVE;
			end
			PH_BYP_PULSE: begin
				if (model_timer >= tuner_cfg[REG_BYPASS_PULSE])
					drop_to_idle(ST_OK);
			end
			PH_KEY_LOW_WAIT: begin
				if (!p.key_level) begin
					model_phase  = PH_START_HOLD;
					model_status = ST_SEND_RF;
					model_timer  = '0;
				end else if (model_timer >= tuner_cfg[REG_KEY_WAIT]) begin
					drop_to_idle(ST_FAIL_KEYWAIT);
				end
			end
			PH_START_HOLD: begin
				// status stays at the RF request
				if (model_timer >= tuner_cfg[REG_START_HOLD]) begin
					model_start = 1'b0;
					model_phase = PH_KEY_HIGH_WAIT;
				end
			end
			PH_KEY_HIGH_WAIT: begin
				if (p.key_level) begin
					model_phase  = PH_ERR_WINDOW;
					model_status = ST_KEY_HIGH;
					model_timer  = '0;
				end
			end
			default: begin
				// error window: a low KEY here is a failed tune
				if (!p.key_level)
					drop_to_idle(ST_FAIL_PULSE);
				else if (model_timer >= tuner_cfg[REG_ERROR_WINDOW])
					drop_to_idle(ST_OK);
			end
		endcase
		r.status_byte = model_status;
		r.start_level = model_start;
		r.phase_now   = model_phase;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Scripted opening sequence, run with the reset thresholds
	// (timeout 4000, bypass 70, KEY wait 600, START hold 250, window 60)
	// ------------------------------------------------------------------
	script_row_t script [25] = '{
		// idle poll, nothing written
		'{'{1'b1, 1'b0, ST_OK, 8'd0}, 1'b1, '{ST_OK, 1'b0, PH_IDLE}},
		// all-ones write and longest gap while idle: status only
		'{'{1'b0, 1'b1, 8'hFF, 8'd255}, 1'b1, '{8'hFF, 1'b0, PH_IDLE}},
		'{'{1'b1, 1'b1, ST_CMD_TUNE, 8'd0}, 1'b1, '{ST_CMD_TUNE, 1'b0, PH_TUNE_REQ}},
		// KEY already low when the tune is requested
		'{'{1'b0, 1'b0, ST_OK, 8'd0}, 1'b1, '{ST_FAIL_NOKEY, 1'b0, PH_IDLE}},
		'{'{1'b1, 1'b1, ST_CMD_TUNE, 8'd5}, 1'b0, '{ST_OK, 1'b0, PH_IDLE}},
		'{'{1'b1, 1'b0, ST_OK, 8'd0}, 1'b1, '{ST_KEY_WAIT, 1'b1, PH_KEY_LOW_WAIT}},
		// host overwrites the status while the tuner is busy
		'{'{1'b1, 1'b1, 8'h55, 8'd255}, 1'b0, '{ST_OK, 1'b0, PH_IDLE}},
		'{'{1'b1, 1'b0, ST_OK, 8'd255}, 1'b0, '{ST_OK, 1'b0, PH_IDLE}},
		// KEY never drops: wait expires at exactly the threshold
		'{'{1'b1, 1'b0, ST_OK, 8'd90}, 1'b1, '{ST_FAIL_KEYWAIT, 1'b0, PH_IDLE}},
		'{'{1'b1, 1'b1, ST_CMD_TUNE, 8'd0}, 1'b0, '{ST_OK, 1'b0, PH_IDLE}},
		'{'{1'b1, 1'b0, ST_OK, 8'd100}, 1'b0, '{ST_OK, 1'b0, PH_IDLE}},
		'{'{1'b0, 1'b0, ST_OK, 8'd3}, 1'b1, '{ST_SEND_RF, 1'b1, PH_START_HOLD}},
		'{'{1'b0, 1'b0, ST_OK, 8'd200}, 1'b0, '{ST_OK, 1'b0, PH_IDLE}},
		'{'{1'b1, 1'b0, ST_OK, 8'd50}, 1'b0, '{ST_OK, 1'b0, PH_IDLE}},
		'{'{1'b1, 1'b0, ST_OK, 8'd0}, 1'b1, '{ST_KEY_HIGH, 1'b0, PH_ERR_WINDOW}},
		// KEY drops inside the error window
		'{'{1'b0, 1'b0, ST_OK, 8'd0}, 1'b1, '{ST_FAIL_PULSE, 1'b0, PH_IDLE}},
		'{'{1'b1, 1'b1, ST_CMD_BYPASS, 8'd0}, 1'b0, '{ST_OK, 1'b0, PH_IDLE}},
		'{'{1'b0, 1'b0, ST_OK, 8'd30}, 1'b1, '{ST_BYP_ACTIVE, 1'b1, PH_BYP_PULSE}},
		'{'{1'b0, 1'b0, ST_OK, 8'd40}, 1'b1, '{ST_OK, 1'b0, PH_IDLE}},
		// clean tune from request to success
		'{'{1'b1, 1'b1, ST_CMD_TUNE, 8'd0}, 1'b0, '{ST_OK, 1'b0, PH_IDLE}},
		'{'{1'b1, 1'b0, ST_OK, 8'd0}, 1'b0, '{ST_OK, 1'b0, PH_IDLE}},
		'{'{1'b0, 1'b0, ST_OK, 8'd0}, 1'b0, '{ST_OK, 1'b0, PH_IDLE}},
		'{'{1'b0, 1'b0, ST_OK, 8'd255}, 1'b0, '{ST_OK, 1'b0, PH_IDLE}},
		'{'{1'b1, 1'b0, ST_OK, 8'd0}, 1'b0, '{ST_OK, 1'b0, PH_IDLE}},
		'{'{1'b1, 1'b0, ST_OK, 8'd60}, 1'b1, '{ST_OK, 1'b0, PH_IDLE}}
	};

	// ------------------------------------------------------------------
	// Clock: 2 ns period
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Poll sender: bursts of random length separated by random gaps.
	// Called at a rising edge; returns at the edge that accepted the poll.
	// ------------------------------------------------------------------
	task automatic send_poll(input poll_t p);
		int gap;
		if (burst_left == 0) begin
			// a zero gap keeps valid high across bursts
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				poll_bus.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		poll_bus.valid            <= 1'b1;
		poll_bus.key_level        <= p.key_level;
		poll_bus.host_write_valid <= p.host_write_valid;
		poll_bus.host_write_value <= p.host_write_value;
		poll_bus.elapsed_ms       <= p.elapsed_ms;
		do @(posedge clk); while (!poll_bus.ready);
		burst_left--;
	endtask

	// Build a poll; the scale picks how fast milliseconds pile up.
	function automatic poll_t make_poll(input logic key, input logic wr,
			input logic [7:0] wval, input int scale);
		poll_t p;
		p.key_level        = key;
		p.host_write_valid = wr;
		p.host_write_value = wval;
		case (scale)
			0:       p.elapsed_ms = 8'($urandom_range(0, 2));
			1:       p.elapsed_ms = 8'($urandom_range(0, 20));
			2:       p.elapsed_ms = 8'($urandom_range(0, 80));
			3:       p.elapsed_ms = 8'($urandom_range(0, 255));
			default: p.elapsed_ms = 8'($urandom_range(200, 255));
		endcase
		return p;
	endfunction

	// Random sessions until n_items polls are accepted. Most sessions follow
	// the real tuner sequence; the rest are broken sequences and noise.
	// With squeeze set, ask the receiver for a long hold-off partway through.
	task automatic run_traffic(input int n_items, input bit squeeze);
		int sent;
		int kind;
		int scale;
		poll_t p;
		poll_t session_q [$];
		sent = 0;
		while (sent < n_items) begin
			session_q.delete();
			kind  = $urandom_range(0, 99);
			scale = $urandom_range(0, 4);
			if (kind < 45) begin
				// tune: request, KEY high, KEY low through the hold, KEY back high
				session_q.push_back(make_poll(1'b1, 1'b1, ST_CMD_TUNE, scale));
				repeat ($urandom_range(0, 5))
					session_q.push_back(make_poll(1'b1, 1'b0, 8'($urandom), scale));
				repeat ($urandom_range(1, 8))
					session_q.push_back(make_poll(1'b0, 1'b0, 8'($urandom), scale));
				repeat ($urandom_range(1, 6))
					session_q.push_back(make_poll(1'b1, 1'b0, 8'($urandom), scale));
				// tuner sometimes pulls KEY low again to report failure
				if ($urandom_range(0, 3) == 0)
					session_q.push_back(make_poll(1'b0, 1'b0, 8'($urandom), scale));
			end else if (kind < 65) begin
				session_q.push_back(make_poll(1'($urandom), 1'b1, ST_CMD_BYPASS, scale));
				repeat ($urandom_range(1, 6))
					session_q.push_back(make_poll(1'($urandom), 1'b0, 8'($urandom),
						scale));
			end else if (kind < 85) begin
				// broken tune: KEY toggles at random
				session_q.push_back(make_poll(1'($urandom), 1'b1, ST_CMD_TUNE, scale));
				repeat ($urandom_range(2, 10))
					session_q.push_back(make_poll(1'($urandom), 1'b0, 8'($urandom),
						scale));
			end else begin
				repeat ($urandom_range(1, 6))
					session_q.push_back(make_poll(1'($urandom), 1'($urandom),
						8'($urandom), scale));
			end
			foreach (session_q[i]) begin
				p = session_q[i];
				// stray host write on top of the sequence
				if (!p.host_write_valid && $urandom_range(0, 31) == 0) begin
					p.host_write_valid = 1'b1;
					p.host_write_value = 8'($urandom);
				end
				send_poll(p);
				sent++;
				if (squeeze && sent == 60)
					long_stall_req = 1'b1;
			end
		end
		poll_bus.valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// APB register write: setup cycle, then access until pready
	// ------------------------------------------------------------------
	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= DATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		tuner_cfg[idx] = val;
	endtask

	task automatic write_thresholds(input logic [CFG_W-1:0] timeout,
			input logic [CFG_W-1:0] pulse, input logic [CFG_W-1:0] key_wait,
			input logic [CFG_W-1:0] hold, input logic [CFG_W-1:0] window);
		write_reg(REG_OVERALL_TIMEOUT, timeout);
		write_reg(REG_BYPASS_PULSE, pulse);
		write_reg(REG_KEY_WAIT, key_wait);
		write_reg(REG_START_HOLD, hold);
		write_reg(REG_ERROR_WINDOW, window);
	endtask

	// Hold until every expected result is back, then let the pipe empty.
	task automatic drain_results();
		while (status_expect_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Result receiver: ready follows a changing pattern, plus one long
	// hold-off on request so that the input side backs up and stalls
	// ------------------------------------------------------------------
	initial begin : result_receiver
		int hold_left;
		int pat_mode;
		int pat_left;
		int pat_step;
		hold_left = 0;
		pat_mode  = 0;
		pat_left  = 0;
		pat_step  = 0;
		result_bus.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_stall_req) begin
				hold_left = SQUEEZE_CYCLES;
				long_stall_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_bus.ready <= 1'b0;
			end else begin
				if (pat_left == 0) begin
					pat_mode = $urandom_range(0, 3);
					pat_left = $urandom_range(16, 96);
				end
				pat_left--;
				pat_step++;
				case (pat_mode)
					0:       result_bus.ready <= 1'b1;
					1:       result_bus.ready <= 1'($urandom);
					2:       result_bus.ready <= (pat_step % 3 == 0);
					default: result_bus.ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: check each result against the oldest expectation, then
	// predict the result of any poll taken at this edge
	// ------------------------------------------------------------------
	always @(posedge clk) begin : status_monitor
		tuner_out_t want;
		pin_t pin;
		bit moved;
		moved = 1'b0;
		if (result_bus.valid && result_bus.ready) begin
			moved = 1'b1;
			if (status_expect_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: unexpected result status %h start %b phase %0d",
						$time, result_bus.status_byte, result_bus.start_level,
						result_bus.phase_now);
			end else begin
				want = status_expect_q.pop_front();
				if (result_bus.status_byte !== want.status_byte ||
						result_bus.start_level !== want.start_level ||
						result_bus.phase_now !== want.phase_now) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"%0t: result mismatch: status exp %h got %h, ",
							"start exp %b got %b, phase exp %0d got %0d"}, $time,
							want.status_byte, result_bus.status_byte,
							want.start_level, result_bus.start_level,
							want.phase_now, result_bus.phase_now);
				end
			end
		end
		if (poll_bus.valid && poll_bus.ready) begin
			moved = 1'b1;
			want = advance_tuner_model('{poll_bus.key_level,
				poll_bus.host_write_valid, poll_bus.host_write_value,
				poll_bus.elapsed_ms});
			// scripted rows may replace the prediction with a fixed value
			if (pinned_q.size() != 0) begin
				pin = pinned_q.pop_front();
				if (pin.pinned)
					want = pin.want;
			end
			status_expect_q.push_back(want);
		end
		if (psel && penable && pwrite && pready)
			moved = 1'b1;
		idle_cycles = moved ? 0 : idle_cycles + 1;
	end

	// ------------------------------------------------------------------
	// Watchdog: end the run if nothing moves for too long
	// ------------------------------------------------------------------
	initial begin : hang_watchdog
		@(posedge arst_n);
		while (idle_cycles < HANG_LIMIT) @(posedge clk);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : main_sequence
		arst_n                      <= 1'b0;
		psel                        <= 1'b0;
		penable                     <= 1'b0;
		pwrite                      <= 1'b0;
		paddr                       <= '0;
		pwdata                      <= '0;
		poll_bus.valid              <= 1'b0;
		poll_bus.key_level          <= 1'b0;
		poll_bus.host_write_valid   <= 1'b0;
		poll_bus.host_write_value   <= '0;
		poll_bus.elapsed_ms         <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// scripted sequence on the reset thresholds, then random on the same
		foreach (script[i]) begin
			pinned_q.push_back('{script[i].pinned, script[i].want});
			send_poll(script[i].stim);
		end
		run_traffic(200, 1'b0);

		// all thresholds zero: every active phase times out at once
		drain_results();
		write_thresholds('0, '0, '0, '0, '0);
		run_traffic(225, 1'b1);

		// all thresholds at maximum: only a saturated timer reaches a threshold
		drain_results();
		write_thresholds('1, '1, '1, '1, '1);
		run_traffic(225, 1'b0);

		// short thresholds so that every phase completes
		drain_results();
		write_thresholds(CFG_W'($urandom_range(0, 80)), CFG_W'($urandom_range(0, 80)),
			CFG_W'($urandom_range(0, 80)), CFG_W'($urandom_range(0, 80)),
			CFG_W'($urandom_range(0, 80)));
		run_traffic(225, 1'b1);

		// short overall timeout against longer phase thresholds
		drain_results();
		write_thresholds(CFG_W'($urandom_range(30, 200)),
			CFG_W'($urandom_range(0, 400)), CFG_W'($urandom_range(0, 400)),
			CFG_W'($urandom_range(0, 400)), CFG_W'($urandom_range(0, 400)));
		run_traffic(225, 1'b0);

		// anything in range
		drain_results();
		write_thresholds(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
			CFG_W'($urandom), CFG_W'($urandom));
		run_traffic(225, 1'b1);

		drain_results();
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
